// ----- sv/mpbm_pkg.sv -----
package mpbm_pkg;

  localparam int NUM_STATES_DEF      = 1024;
  localparam int NUM_PATTERNS_DEF    = 256;
  localparam int MAX_PATTERN_LEN_DEF = 32;
  localparam int ALPHABET_DEF        = 256;

  // hits reported per scanned byte at most
  localparam int HIT_LIMIT = 32;
  localparam int HIT_W     = $clog2(HIT_LIMIT + 1);

  localparam int MODE_W      = 3;
  localparam int STATE_IDX_W = 10;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 8;
  localparam int POS_W       = 32;
  localparam int CNT_W       = 32;

  localparam logic [MODE_W-1:0] MODE_GOTO_WR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INFO_WR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_CNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEW_TEXT = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_FAIL_RD,
    S_FAIL_CHK,
    S_CH_RD,
    S_CH_CHK,
    S_CNT_UPD,
    S_HIT,
    S_DONE,
    S_RD_OUT
  } seq_state_t;

  typedef struct packed {
    logic goto_wr;
    logic goto_rd;
    logic info_wr;
    logic info_rd;
    logic end_clr;
  } auto_cmd_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic bump;
  } cnt_cmd_t;

endpackage

// ----- sv/mpbm_in_if.sv -----
interface mpbm_in_if;
  logic                            valid;
  logic                            ready;
  logic [mpbm_pkg::MODE_W-1:0]      mode;
  logic [mpbm_pkg::STATE_IDX_W-1:0] state_index;
  logic [mpbm_pkg::BYTE_W-1:0]      byte_value;
  logic [mpbm_pkg::STATE_IDX_W-1:0] next_state;
  logic [mpbm_pkg::PAT_W-1:0]       pattern_id;
  logic                            is_end;

  modport source (
    output valid, mode, state_index, byte_value, next_state, pattern_id, is_end,
    input  ready
  );

  modport sink (
    input  valid, mode, state_index, byte_value, next_state, pattern_id, is_end,
    output ready
  );
endinterface

// ----- sv/mpbm_out_if.sv -----
interface mpbm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        match_found;
  logic [mpbm_pkg::PAT_W-1:0]  matched_pattern;
  logic [mpbm_pkg::POS_W-1:0]  text_position;
  logic [mpbm_pkg::CNT_W-1:0]  pattern_count;
  logic                        last;

  modport source (
    output valid, match_found, matched_pattern, text_position, pattern_count, last,
    input  ready
  );

  modport sink (
    input  valid, match_found, matched_pattern, text_position, pattern_count, last,
    output ready
  );
endinterface

// ----- sv/mpbm_automaton.sv -----
module mpbm_automaton #(
  parameter int NUM_STATES = mpbm_pkg::NUM_STATES_DEF,
  parameter int ALPHABET   = mpbm_pkg::ALPHABET_DEF,
  localparam int SW = $clog2(NUM_STATES),
  localparam int AW = $clog2(ALPHABET),
  localparam int GW = SW + AW
) (
  input  logic                      clk,
  input  mpbm_pkg::auto_cmd_t       cmd,
  input  logic [GW-1:0]             goto_addr,
  input  logic [SW-1:0]             info_addr,
  input  logic [SW-1:0]             goto_wdata,
  input  logic [SW-1:0]             fail_wdata,
  input  logic                      end_wdata,
  input  logic [mpbm_pkg::PAT_W-1:0] pat_wdata,
  output logic [SW-1:0]             goto_rdata,
  output logic [SW-1:0]             fail_rdata,
  output logic                      end_rdata,
  output logic [mpbm_pkg::PAT_W-1:0] pat_rdata
);

  localparam int GOTO_DEPTH = NUM_STATES << AW;

  logic [SW-1:0]                  goto_mem [GOTO_DEPTH];
  logic [SW+mpbm_pkg::PAT_W-1:0]  link_mem [NUM_STATES];
  logic                           end_mem  [NUM_STATES];

  always_ff @(posedge clk) begin
    if (cmd.goto_wr) begin
      goto_mem[goto_addr] <= goto_wdata;
    end
    if (cmd.goto_rd) begin
      goto_rdata <= goto_mem[goto_addr];
    end
  end

  // failure link and pattern id live together, end marks are kept apart
  always_ff @(posedge clk) begin
    if (cmd.info_wr) begin
      link_mem[info_addr] <= {fail_wdata, pat_wdata};
    end
    if (cmd.info_rd) begin
      {fail_rdata, pat_rdata} <= link_mem[info_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.info_wr) begin
      end_mem[info_addr] <= end_wdata;
    end else if (cmd.end_clr) begin
      end_mem[info_addr] <= 1'b0;
    end
    if (cmd.info_rd) begin
      end_rdata <= end_mem[info_addr];
    end
  end

endmodule

// ----- sv/mpbm_counts.sv -----
module mpbm_counts #(
  parameter int NUM_PATTERNS = mpbm_pkg::NUM_PATTERNS_DEF,
  localparam int PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1
) (
  input  logic                       clk,
  input  mpbm_pkg::cnt_cmd_t         cmd,
  input  logic [PW-1:0]              addr,
  output logic [mpbm_pkg::CNT_W-1:0] rdata,
  output logic [mpbm_pkg::CNT_W-1:0] bumped
);

  logic [mpbm_pkg::CNT_W-1:0] cnt_mem [NUM_PATTERNS];

  // saturating increment of the last value read
  assign bumped = (rdata == '1) ? rdata : rdata + mpbm_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      cnt_mem[addr] <= '0;
    end else if (cmd.bump) begin
      cnt_mem[addr] <= bumped;
    end
    if (cmd.rd) begin
      rdata <= cnt_mem[addr];
    end
  end

endmodule

// ----- sv/multi_pattern_byte_matcher.sv -----
// Aho-Corasick scanner over a goto/failure automaton that software loads one
// entry per transaction (goto edges, then per state the failure link, end mark
// and pattern id). A scan byte follows failure links, takes its goto edge, then
// walks the output chain; each end-marked state visited gives one match result
// (longest match first, last set on the final one) and bumps a saturating 32-bit
// counter if its pattern id is in range; a single no-match result is given if
// nothing ends there. Counts are read with one result each; new text resets
// the state and position only. Each scan step reads the single-ported automaton
// memory with one registered access, and a full result channel stalls scans
// and count reads. After reset a clearing pass over the larger of the goto
// table depth and NUM_PATTERNS zeroes the goto table, end marks and counters;
// no transaction is accepted during it.
module multi_pattern_byte_matcher #(
  parameter int NUM_STATES      = mpbm_pkg::NUM_STATES_DEF,
  parameter int NUM_PATTERNS    = mpbm_pkg::NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = mpbm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int ALPHABET        = mpbm_pkg::ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mpbm_in_if.sink           items,
  mpbm_out_if.source        results
);

  localparam int SW         = $clog2(NUM_STATES);
  localparam int AW         = $clog2(ALPHABET);
  localparam int GW         = SW + AW;
  localparam int PW         = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int GOTO_DEPTH = NUM_STATES << AW;
  localparam int CLR_DEPTH  = (GOTO_DEPTH > NUM_PATTERNS) ? GOTO_DEPTH : NUM_PATTERNS;
  localparam int CW         = $clog2(CLR_DEPTH);
  localparam int SCW        = $clog2(MAX_PATTERN_LEN + 1);
  localparam int HW         = mpbm_pkg::HIT_W;
  localparam int PATW       = mpbm_pkg::PAT_W;
  localparam int CNTW       = mpbm_pkg::CNT_W;
  localparam int POSW       = mpbm_pkg::POS_W;

  mpbm_pkg::seq_state_t state, state_next;

  logic [CW-1:0]                    clr_idx, clr_idx_next;
  logic [mpbm_pkg::MODE_W-1:0]      it_mode;
  logic [mpbm_pkg::STATE_IDX_W-1:0] it_sidx;
  logic [mpbm_pkg::BYTE_W-1:0]      it_byte;
  logic [mpbm_pkg::STATE_IDX_W-1:0] it_next;
  logic [PATW-1:0]                  it_pid;
  logic                             it_end;
  logic [SW-1:0]                    cur_state, cur_state_next;
  logic [POSW-1:0]                  byte_pos, byte_pos_next;
  logic [SW-1:0]                    st, st_next;
  logic [SCW-1:0]                   steps, steps_next;
  logic [HW-1:0]                    hit_n, hit_n_next;
  logic                             held_valid, held_valid_next;
  logic [PATW-1:0]                  held_pat, held_pat_next;
  logic [CNTW-1:0]                  held_cnt, held_cnt_next;
  logic [PATW-1:0]                  nh_pat, nh_pat_next;
  logic [CNTW-1:0]                  nh_cnt, nh_cnt_next;

  logic                             out_valid, out_valid_next;
  logic                             out_found, out_found_next;
  logic [PATW-1:0]                  out_pat, out_pat_next;
  logic [POSW-1:0]                  out_pos, out_pos_next;
  logic [CNTW-1:0]                  out_cnt, out_cnt_next;
  logic                             out_last, out_last_next;
  logic                             load_out;

  mpbm_pkg::auto_cmd_t              acmd;
  mpbm_pkg::cnt_cmd_t               ccmd;
  logic [GW-1:0]                    goto_addr;
  logic [SW-1:0]                    info_addr;
  logic [SW-1:0]                    goto_wdata;
  logic [SW-1:0]                    goto_rdata;
  logic [SW-1:0]                    fail_rdata;
  logic                             end_rdata;
  logic [PATW-1:0]                  pat_rdata;
  logic [PW-1:0]                    cnt_addr;
  logic [CNTW-1:0]                  cnt_rdata;
  logic [CNTW-1:0]                  cnt_bumped;

  logic can_load, sidx_ok, nxt_ok, byte_ok, pid_ok, pat_ok, chain_go;
  logic [SW-1:0] edge_eff;

  mpbm_automaton #(
    .NUM_STATES (NUM_STATES),
    .ALPHABET   (ALPHABET)
  ) u_automaton (
    .clk        (clk),
    .cmd        (acmd),
    .goto_addr  (goto_addr),
    .info_addr  (info_addr),
    .goto_wdata (goto_wdata),
    .fail_wdata (SW'(it_next)),
    .end_wdata  (it_end),
    .pat_wdata  (it_pid),
    .goto_rdata (goto_rdata),
    .fail_rdata (fail_rdata),
    .end_rdata  (end_rdata),
    .pat_rdata  (pat_rdata)
  );

  mpbm_counts #(
    .NUM_PATTERNS (NUM_PATTERNS)
  ) u_counts (
    .clk    (clk),
    .cmd    (ccmd),
    .addr   (cnt_addr),
    .rdata  (cnt_rdata),
    .bumped (cnt_bumped)
  );

  assign items.ready = (state == mpbm_pkg::S_IDLE);

  assign results.valid           = out_valid;
  assign results.match_found     = out_found;
  assign results.matched_pattern = out_pat;
  assign results.text_position   = out_pos;
  assign results.pattern_count   = out_cnt;
  assign results.last            = out_last;

  assign can_load = !out_valid || results.ready;
  assign sidx_ok  = 32'(it_sidx) < NUM_STATES;
  assign nxt_ok   = 32'(it_next) < NUM_STATES;
  assign byte_ok  = 32'(it_byte) < ALPHABET;
  assign pid_ok   = 32'(it_pid) < NUM_PATTERNS;
  assign pat_ok   = 32'(pat_rdata) < NUM_PATTERNS;
  // a byte outside the alphabet has no edge anywhere
  assign edge_eff = byte_ok ? goto_rdata : '0;
  assign chain_go = (st != '0) && (steps < SCW'(MAX_PATTERN_LEN))
                    && (hit_n < HW'(mpbm_pkg::HIT_LIMIT));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mpbm_pkg::S_CLEAR: begin
        if (32'(clr_idx) == CLR_DEPTH - 1) state_next = mpbm_pkg::S_IDLE;
      end
      mpbm_pkg::S_IDLE: begin
        if (items.valid) state_next = mpbm_pkg::S_DISPATCH;
      end
      mpbm_pkg::S_DISPATCH: begin
        if (it_mode == mpbm_pkg::MODE_SCAN) begin
          state_next = mpbm_pkg::S_FAIL_RD;
        end else if (it_mode == mpbm_pkg::MODE_READ_CNT) begin
          state_next = mpbm_pkg::S_RD_OUT;
        end else begin
          state_next = mpbm_pkg::S_IDLE;
        end
      end
      mpbm_pkg::S_FAIL_RD: state_next = mpbm_pkg::S_FAIL_CHK;
      mpbm_pkg::S_FAIL_CHK: begin
        if (edge_eff != '0 || st == '0) state_next = mpbm_pkg::S_CH_RD;
        else state_next = mpbm_pkg::S_FAIL_RD;
      end
      mpbm_pkg::S_CH_RD: begin
        state_next = chain_go ? mpbm_pkg::S_CH_CHK : mpbm_pkg::S_DONE;
      end
      mpbm_pkg::S_CH_CHK: begin
        if (!end_rdata) state_next = mpbm_pkg::S_CH_RD;
        else if (pat_ok) state_next = mpbm_pkg::S_CNT_UPD;
        else state_next = mpbm_pkg::S_HIT;
      end
      mpbm_pkg::S_CNT_UPD: state_next = mpbm_pkg::S_HIT;
      mpbm_pkg::S_HIT: begin
        if (!held_valid || can_load) state_next = mpbm_pkg::S_CH_RD;
      end
      mpbm_pkg::S_DONE, mpbm_pkg::S_RD_OUT: begin
        if (can_load) state_next = mpbm_pkg::S_IDLE;
      end
      default: state_next = mpbm_pkg::S_IDLE;
    endcase
  end

  // datapath control and memory commands
  always_comb begin
    acmd            = '0;
    ccmd            = '0;
    goto_addr       = {st, it_byte[AW-1:0]};
    info_addr       = st;
    goto_wdata      = SW'(it_next);
    cnt_addr        = PW'(nh_pat);
    clr_idx_next    = clr_idx;
    cur_state_next  = cur_state;
    byte_pos_next   = byte_pos;
    st_next         = st;
    steps_next      = steps;
    hit_n_next      = hit_n;
    held_valid_next = held_valid;
    held_pat_next   = held_pat;
    held_cnt_next   = held_cnt;
    nh_pat_next     = nh_pat;
    nh_cnt_next     = nh_cnt;
    load_out        = 1'b0;
    out_found_next  = out_found;
    out_pat_next    = out_pat;
    out_pos_next    = out_pos;
    out_cnt_next    = out_cnt;
    out_last_next   = out_last;

    unique case (state)
      mpbm_pkg::S_CLEAR: begin
        acmd.goto_wr = 32'(clr_idx) < GOTO_DEPTH;
        goto_addr    = clr_idx[GW-1:0];
        goto_wdata   = '0;
        acmd.end_clr = 32'(clr_idx) < NUM_STATES;
        info_addr    = clr_idx[SW-1:0];
        ccmd.clr     = 32'(clr_idx) < NUM_PATTERNS;
        cnt_addr     = clr_idx[PW-1:0];
        clr_idx_next = clr_idx + CW'(1);
      end
      mpbm_pkg::S_IDLE: ;
      mpbm_pkg::S_DISPATCH: begin
        unique case (it_mode)
          mpbm_pkg::MODE_GOTO_WR: begin
            acmd.goto_wr = sidx_ok && nxt_ok && byte_ok;
            goto_addr    = {SW'(it_sidx), it_byte[AW-1:0]};
          end
          mpbm_pkg::MODE_INFO_WR: begin
            acmd.info_wr = sidx_ok && nxt_ok;
            info_addr    = SW'(it_sidx);
          end
          mpbm_pkg::MODE_SCAN: begin
            st_next    = cur_state;
            steps_next = '0;
          end
          mpbm_pkg::MODE_READ_CNT: begin
            ccmd.rd  = pid_ok;
            cnt_addr = PW'(it_pid);
          end
          mpbm_pkg::MODE_NEW_TEXT: begin
            cur_state_next = '0;
            byte_pos_next  = '0;
          end
          default: ;
        endcase
      end
      mpbm_pkg::S_FAIL_RD: begin
        acmd.goto_rd = 1'b1;
        acmd.info_rd = 1'b1;
      end
      mpbm_pkg::S_FAIL_CHK: begin
        if (edge_eff != '0 || st == '0) begin
          // walk ends: take the edge if any, then start the output chain
          st_next         = (edge_eff != '0) ? edge_eff : st;
          cur_state_next  = (edge_eff != '0) ? edge_eff : st;
          steps_next      = '0;
          hit_n_next      = '0;
          held_valid_next = 1'b0;
        end else if (steps >= SCW'(MAX_PATTERN_LEN)) begin
          // looping links: fall back to the root and retry its edge
          st_next = '0;
        end else begin
          st_next    = fail_rdata;
          steps_next = steps + SCW'(1);
        end
      end
      mpbm_pkg::S_CH_RD: begin
        acmd.info_rd = chain_go;
      end
      mpbm_pkg::S_CH_CHK: begin
        st_next    = fail_rdata;
        steps_next = steps + SCW'(1);
        if (end_rdata) begin
          nh_pat_next = pat_rdata;
          nh_cnt_next = '0;
          ccmd.rd     = pat_ok;
          cnt_addr    = PW'(pat_rdata);
        end
      end
      mpbm_pkg::S_CNT_UPD: begin
        ccmd.bump   = 1'b1;
        nh_cnt_next = cnt_bumped;
      end
      mpbm_pkg::S_HIT: begin
        // the held hit is not the last one once another follows it
        if (!held_valid || can_load) begin
          load_out        = held_valid;
          out_found_next  = 1'b1;
          out_pat_next    = held_pat;
          out_pos_next    = byte_pos;
          out_cnt_next    = held_cnt;
          out_last_next   = 1'b0;
          held_valid_next = 1'b1;
          held_pat_next   = nh_pat;
          held_cnt_next   = nh_cnt;
          hit_n_next      = hit_n + HW'(1);
        end
      end
      mpbm_pkg::S_DONE: begin
        if (can_load) begin
          load_out       = 1'b1;
          out_found_next = held_valid;
          out_pat_next   = held_valid ? held_pat : '0;
          out_pos_next   = byte_pos;
          out_cnt_next   = held_valid ? held_cnt : '0;
          out_last_next  = 1'b1;
          byte_pos_next  = byte_pos + POSW'(1);
        end
      end
      mpbm_pkg::S_RD_OUT: begin
        if (can_load) begin
          load_out       = 1'b1;
          out_found_next = 1'b0;
          out_pat_next   = it_pid;
          out_pos_next   = '0;
          out_cnt_next   = pid_ok ? cnt_rdata : '0;
          out_last_next  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load_out) out_valid_next = 1'b1;
    else if (results.ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mpbm_pkg::S_CLEAR;
      clr_idx    <= '0;
      cur_state  <= '0;
      byte_pos   <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      cur_state  <= cur_state_next;
      byte_pos   <= byte_pos_next;
      held_valid <= held_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      it_mode <= items.mode;
      it_sidx <= items.state_index;
      it_byte <= items.byte_value;
      it_next <= items.next_state;
      it_pid  <= items.pattern_id;
      it_end  <= items.is_end;
    end
    st        <= st_next;
    steps     <= steps_next;
    hit_n     <= hit_n_next;
    held_pat  <= held_pat_next;
    held_cnt  <= held_cnt_next;
    nh_pat    <= nh_pat_next;
    nh_cnt    <= nh_cnt_next;
    if (load_out) begin
      out_found <= out_found_next;
      out_pat   <= out_pat_next;
      out_pos   <= out_pos_next;
      out_cnt   <= out_cnt_next;
      out_last  <= out_last_next;
    end
  end

endmodule

// ----- tb/mpbm_sb_pkg.sv -----
`timescale 1ns / 100ps
package mpbm_sb_pkg;
  import mpbm_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [STATE_IDX_W-1:0] state_index;
    logic [BYTE_W-1:0]      byte_value;
    logic [STATE_IDX_W-1:0] next_state;
    logic [PAT_W-1:0]       pattern_id;
    logic                   is_end;
  } matcher_req_t;

  typedef struct packed {
    logic             match_found;
    logic [PAT_W-1:0] matched_pattern;
    logic [POS_W-1:0] text_position;
    logic [CNT_W-1:0] pattern_count;
    logic             last;
  } matcher_rsp_t;

  class match_scoreboard;
    // shadow automaton, goto edges keyed by {state, byte}
    logic [STATE_IDX_W-1:0] goto_edge [int];
    logic [STATE_IDX_W-1:0] fail_link [NUM_STATES_DEF];
    logic                   end_mark  [NUM_STATES_DEF];
    logic [PAT_W-1:0]       state_pid [NUM_STATES_DEF];
    logic [CNT_W-1:0]       hit_count [NUM_PATTERNS_DEF];
    logic [STATE_IDX_W-1:0] cur_state;
    logic [POS_W-1:0]       position;
    matcher_rsp_t           due_results [$];
    int errors;
    int checked;
    int hits_seen;
    int scans;

    function new();
      foreach (fail_link[i]) begin
        fail_link[i] = '0;
        end_mark[i]  = 1'b0;
        state_pid[i] = '0;
      end
      foreach (hit_count[i]) begin
        hit_count[i] = '0;
      end
      cur_state = '0;
      position  = '0;
      errors    = 0;
      checked   = 0;
      hits_seen = 0;
      scans     = 0;
    endfunction

    function logic [STATE_IDX_W-1:0] edge_at(logic [STATE_IDX_W-1:0] st, logic [BYTE_W-1:0] b);
      int key;
      key = int'({st, b});
      if (goto_edge.exists(key)) return goto_edge[key];
      return '0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void predict_scan(logic [BYTE_W-1:0] b);
      logic [STATE_IDX_W-1:0] st;
      logic [STATE_IDX_W-1:0] w;
      logic [STATE_IDX_W-1:0] e;
      logic [PAT_W-1:0]       p;
      int steps;
      int visited;
      matcher_rsp_t hits [$];
      matcher_rsp_t r;
      st    = cur_state;
      steps = 0;
      // failure walk, forced back to root once the step budget is spent
      while (st != '0 && edge_at(st, b) == '0) begin
        if (steps >= MAX_PATTERN_LEN_DEF) begin
          st = '0;
          break;
        end
        st = fail_link[st];
        steps++;
      end
      e = edge_at(st, b);
      if (e != '0) st = e;
      cur_state = st;
      // output chain, longest match first
      w       = st;
      visited = 0;
      while (w != '0 && visited < MAX_PATTERN_LEN_DEF && hits.size() < HIT_LIMIT) begin
        if (end_mark[w]) begin
          p = state_pid[w];
          if (hit_count[p] != '1) hit_count[p] = hit_count[p] + 1'b1;
          r.match_found     = 1'b1;
          r.matched_pattern = p;
          r.text_position   = position;
          r.pattern_count   = hit_count[p];
          r.last            = 1'b0;
          hits.push_back(r);
        end
        w = fail_link[w];
        visited++;
      end
      if (hits.size() == 0) begin
        r.match_found     = 1'b0;
        r.matched_pattern = '0;
        r.text_position   = position;
        r.pattern_count   = '0;
        r.last            = 1'b1;
        hits.push_back(r);
      end else begin
        r      = hits.pop_back();
        r.last = 1'b1;
        hits.push_back(r);
      end
      foreach (hits[i]) begin
        due_results.push_back(hits[i]);
      end
      position = position + 1'b1;
      scans++;
    endfunction

    // called for every accepted input transaction
    function void note_item(matcher_req_t req);
      matcher_rsp_t r;
      case (req.mode)
        MODE_GOTO_WR: begin
          goto_edge[int'({req.state_index, req.byte_value})] = req.next_state;
        end
        MODE_INFO_WR: begin
          fail_link[req.state_index] = req.next_state;
          end_mark[req.state_index]  = req.is_end;
          state_pid[req.state_index] = req.pattern_id;
        end
        MODE_SCAN: begin
          predict_scan(req.byte_value);
        end
        MODE_READ_CNT: begin
          r.match_found     = 1'b0;
          r.matched_pattern = req.pattern_id;
          r.text_position   = '0;
          r.pattern_count   = hit_count[req.pattern_id];
          r.last            = 1'b1;
          due_results.push_back(r);
        end
        MODE_NEW_TEXT: begin
          cur_state = '0;
          position  = '0;
        end
        default: begin
        end
      endcase
    endfunction

    // called for every accepted result transaction
    function void check_result(matcher_rsp_t got);
      matcher_rsp_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0d pat=%0d pos=%0d cnt=%0d last=%0d",
                 $time, got.match_found, got.matched_pattern, got.text_position,
                 got.pattern_count, got.last);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.match_found) hits_seen++;
      if (got !== want) begin
        errors++;
        $display({"%0t: mismatch expected found=%0d pat=%0d pos=%0d cnt=%0d last=%0d",
                  " actual found=%0d pat=%0d pos=%0d cnt=%0d last=%0d"},
                 $time, want.match_found, want.matched_pattern, want.text_position,
                 want.pattern_count, want.last, got.match_found, got.matched_pattern,
                 got.text_position, got.pattern_count, got.last);
      end
    endfunction
  endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import mpbm_pkg::*;
  import mpbm_sb_pkg::*;

  // clearing pass after reset dominates the run time
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 34;
  localparam int CHAIN_LEN    = 40;
  localparam int TRIE_EDGES   = 12;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 600;

  logic clk;
  logic rst;

  mpbm_in_if  in_ch ();
  mpbm_out_if out_ch ();

  multi_pattern_byte_matcher i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  match_scoreboard        sb;
  matcher_req_t           seen_req;
  matcher_rsp_t           seen_rsp;
  int unsigned            cycles = 0;
  int                     sent = 0;
  bit                     sender_burst = 1'b0;
  bit                     info_done [NUM_STATES_DEF];
  logic [STATE_IDX_W-1:0] known_states [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        seen_req = {in_ch.mode, in_ch.state_index, in_ch.byte_value, in_ch.next_state,
                    in_ch.pattern_id, in_ch.is_end};
        sb.note_item(seen_req);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen_rsp = {out_ch.match_found, out_ch.matched_pattern, out_ch.text_position,
                    out_ch.pattern_count, out_ch.last};
        sb.check_result(seen_rsp);
      end
    end
  end

  function automatic logic [STATE_IDX_W-1:0] any_state();
    return STATE_IDX_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] label(int k);
    case (k % 8)
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'ha5;
      3:       return 8'h5a;
      4:       return 8'h61;
      5:       return 8'h62;
      6:       return 8'h63;
      default: return 8'h64;
    endcase
  endfunction

  // mostly edge labels so scans walk the automaton
  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 99) < 85) return label($urandom_range(0, 7));
    return any_byte();
  endfunction

  // only states whose failure link and pattern are already loaded
  function automatic logic [STATE_IDX_W-1:0] pick_state();
    return known_states[$urandom_range(0, known_states.size() - 1)];
  endfunction

  task automatic issue(input logic [MODE_W-1:0] mode, input logic [STATE_IDX_W-1:0] s,
                       input logic [BYTE_W-1:0] b, input logic [STATE_IDX_W-1:0] n,
                       input logic [PAT_W-1:0] p, input logic e);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 4);
    if (mode == MODE_INFO_WR && !info_done[s]) begin
      info_done[s] = 1'b1;
      known_states.push_back(s);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.state_index <= s;
    in_ch.byte_value  <= b;
    in_ch.next_state  <= n;
    in_ch.pattern_id  <= p;
    in_ch.is_end      <= e;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sent++;
  endtask

  task automatic scan_tx(input logic [BYTE_W-1:0] b);
    issue(MODE_SCAN, any_state(), b, any_state(), any_byte(), 1'($urandom));
  endtask

  task automatic read_tx(input logic [PAT_W-1:0] p);
    issue(MODE_READ_CNT, any_state(), any_byte(), any_state(), p, 1'($urandom));
  endtask

  task automatic new_text_tx();
    issue(MODE_NEW_TEXT, any_state(), any_byte(), any_state(), any_byte(), 1'($urandom));
  endtask

  task automatic unused_tx(input logic [MODE_W-1:0] m);
    issue(m, any_state(), any_byte(), any_state(), any_byte(), 1'($urandom));
  endtask

  // result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int gap;
    int quiet;
    int taken;
    quiet = 0;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (quiet > 0) begin
        gap = 0;
        quiet--;
      end else begin
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 30);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      taken++;
      if (taken == HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin
    int sel;
    int random_done;
    logic [STATE_IDX_W-1:0] s;
    logic [STATE_IDX_W-1:0] f;
    logic [PAT_W-1:0]       p;
    sb = new();
    foreach (info_done[i]) begin
      info_done[i] = 1'b0;
    end
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_GOTO_WR;
    in_ch.state_index <= '0;
    in_ch.byte_value  <= '0;
    in_ch.next_state  <= '0;
    in_ch.pattern_id  <= '0;
    in_ch.is_end      <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // preload: root, a long end-marked failure chain, the top state, a small trie
    issue(MODE_INFO_WR, '0, any_byte(), '0, '0, 1'b0);
    for (int k = 1; k <= CHAIN_LEN; k++) begin
      issue(MODE_INFO_WR, STATE_IDX_W'(k), any_byte(), STATE_IDX_W'(k - 1), PAT_W'(k), 1'b1);
    end
    issue(MODE_INFO_WR, '1, any_byte(), '0, '0, 1'b0);
    for (int k = 1; k <= TRIE_EDGES; k++) begin
      issue(MODE_GOTO_WR, STATE_IDX_W'(k - 1), label(k), STATE_IDX_W'(k), any_byte(),
            1'($urandom));
    end

    // directed: no edge at root, self-looping failure link, hit limit, walk limit
    scan_tx(8'h3c);
    read_tx('0);
    issue(MODE_GOTO_WR, '0, 8'h00, '1, any_byte(), 1'($urandom));
    issue(MODE_INFO_WR, '1, any_byte(), '1, '1, 1'b1);
    scan_tx(8'h00);
    scan_tx(8'h3c);
    read_tx('1);
    issue(MODE_GOTO_WR, '0, 8'ha5, STATE_IDX_W'(CHAIN_LEN), any_byte(), 1'($urandom));
    scan_tx(8'ha5);
    scan_tx(8'h3c);
    new_text_tx();
    scan_tx(8'hff);
    unused_tx(3'd5);
    unused_tx(3'd6);
    unused_tx(3'd7);
    issue(MODE_GOTO_WR, '1, 8'hff, '1, any_byte(), 1'($urandom));
    issue(MODE_INFO_WR, '1, any_byte(), '0, '0, 1'b0);
    scan_tx(8'h00);
    scan_tx(8'hff);
    issue(MODE_GOTO_WR, '0, 8'h00, '0, any_byte(), 1'($urandom));
    scan_tx(8'h00);
    read_tx(PAT_W'(CHAIN_LEN));

    // random: scans on half the items, over the loaded automaton, which keeps changing under them
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (random_done % 20 == 0) sender_burst = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        scan_tx(pick_byte());
      end else if (sel < 65) begin
        s = ($urandom_range(0, 9) < 8) ? pick_state() : any_state();
        f = ($urandom_range(0, 4) == 0) ? STATE_IDX_W'(0) : pick_state();
        issue(MODE_GOTO_WR, s, pick_byte(), f, any_byte(), 1'($urandom));
      end else if (sel < 77) begin
        s = ($urandom_range(0, 9) < 7) ? pick_state() : any_state();
        f = ($urandom_range(0, 9) == 0) ? s : pick_state();
        p = ($urandom_range(0, 3) == 0) ? any_byte() : PAT_W'($urandom_range(0, 15));
        issue(MODE_INFO_WR, s, any_byte(), f, p, $urandom_range(0, 9) < 6);
      end else if (sel < 90) begin
        p = ($urandom_range(0, 4) == 0) ? any_byte() : PAT_W'($urandom_range(0, CHAIN_LEN));
        read_tx(p);
      end else if (sel < 95) begin
        new_text_tx();
      end else begin
        unused_tx(MODE_W'($urandom_range(5, 7)));
      end
      if (sel < 95) random_done++;
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d transactions sent, %0d scans; %0d results checked, %0d of them hits",
             sent, sb.scans, sb.checked, sb.hits_seen);
    $display("%0d mismatches over %0d automaton states loaded", sb.errors,
             known_states.size());
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mpbm_pkg.sv
sv/mpbm_in_if.sv
sv/mpbm_out_if.sv
sv/mpbm_automaton.sv
sv/mpbm_counts.sv
sv/multi_pattern_byte_matcher.sv
tb/mpbm_sb_pkg.sv
tb/tb.sv
